@@ hw/rtl/qte_pkg.sv @@
// Shared constants, tables and types for the quaternion to Euler angle converter.
package qte_pkg;

	// Defaults for the top-level parameters.
	localparam int COMPONENT_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF     = 16;
	localparam int CORDIC_STAGES_DEF  = 16;

	// Components are brought below 2^COMP_LIMIT_LOG before squaring.
	localparam int COMP_LIMIT_LOG = 29;
	localparam int CMP_W          = COMP_LIMIT_LOG + 1;
	localparam int PROD_W         = 2 * CMP_W;
	localparam int SUM_W          = 64;

	// The squared length is normalized so that its top set bit is NORM_TOP.
	localparam int NORM_TOP = 40;
	localparam int LEN_W    = NORM_TOP + 2;

	// CORDIC datapath: data width with headroom for gain, angle width (pi = 2^31).
	localparam int CORDIC_W = 46;
	localparam int ANG_Z_W  = 34;
	localparam logic signed [63:0] HALF_PI_UNITS = 64'sd1073741824;

	// Gain compensation 1/K in Q20, and the fraction bits of the threshold.
	localparam int GAIN_SHIFT = 20;
	localparam logic [GAIN_SHIFT-1:0] INV_GAIN_Q20 = 20'd636751;
	localparam int THR_BITS = 16;

	// Arctangent of 2^-i, pi = 2^31.
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680094, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	// Normalized rotation-matrix numerators and length handed to the CORDIC banks.
	typedef struct packed {
		logic                       deg;
		logic [LEN_W-1:0]           len;
		logic signed [CORDIC_W-1:0] n00;
		logic signed [CORDIC_W-1:0] n01;
		logic signed [CORDIC_W-1:0] n02;
		logic signed [CORDIC_W-1:0] n10;
		logic signed [CORDIC_W-1:0] n11;
		logic signed [CORDIC_W-1:0] n12;
		logic signed [CORDIC_W-1:0] n22;
	} qte_terms_t;

endpackage

@@ hw/rtl/qte_front.sv @@
// Front end: range scaling, squares and cross products, matrix sums, normalization.
module qte_front #(
	parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [COMPONENT_BITS-1:0] quat_x,
	input  logic signed [COMPONENT_BITS-1:0] quat_y,
	input  logic signed [COMPONENT_BITS-1:0] quat_z,
	input  logic signed [COMPONENT_BITS-1:0] quat_w,
	output logic                             out_valid,
	output qte_pkg::qte_terms_t              terms
);
	import qte_pkg::*;

	localparam int CB = COMPONENT_BITS;

	// Product indexes.
	localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_WW = 3, P_XY = 4;
	localparam int P_ZW = 5, P_XZ = 6, P_YW = 7, P_YZ = 8, P_XW = 9;
	// Sum indexes.
	localparam int T_L = 0, T_00 = 1, T_01 = 2, T_02 = 3;
	localparam int T_10 = 4, T_11 = 5, T_12 = 6, T_22 = 7;

	logic signed [CB-1:0]     q_in [4];
	logic [CB-1:0]            a_in [4];
	logic [CB-1:0]            m01, m23, m_in;
	logic signed [CB-1:0]     q_s1 [4];
	logic [CB-1:0]            m_s1;
	logic                     vld_s1;
	logic [2:0]               sh_s2;
	logic signed [CMP_W-1:0]  c_s2 [4];
	logic                     deg_s2, vld_s2;
	logic signed [PROD_W-1:0] p_s3 [10];
	logic                     deg_s3, vld_s3;
	logic signed [SUM_W-1:0]  t_s4 [8];
	logic signed [SUM_W-1:0]  t_nxt [8];
	logic                     deg_s4, vld_s4;
	logic [5:0]               top_bit;
	logic signed [SUM_W-1:0]  t_s5 [8];
	logic [5:0]               p_s5;
	logic                     deg_s5, vld_s5;
	logic signed [SUM_W-1:0]  t_nrm [8];
	logic [5:0]               sh_r, sh_l;
	qte_terms_t               terms_s6;
	logic                     vld_s6;

	// Stage 1: magnitudes and their maximum.
	always_comb begin
		q_in[0] = quat_x;
		q_in[1] = quat_y;
		q_in[2] = quat_z;
		q_in[3] = quat_w;
		for (int k = 0; k < 4; k++) begin
			a_in[k] = q_in[k][CB-1] ? CB'(-q_in[k]) : CB'(q_in[k]);
		end
		m01  = (a_in[0] > a_in[1]) ? a_in[0] : a_in[1];
		m23  = (a_in[2] > a_in[3]) ? a_in[2] : a_in[3];
		m_in = (m01 > m23) ? m01 : m23;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= q_in;
			m_s1 <= m_in;
		end
	end

	// Stage 2: shift all components right until the largest is below the limit.
	always_comb begin
		sh_s2 = '0;
		for (int j = 0; j < CB; j++) begin
			if (j >= COMP_LIMIT_LOG && m_s1[j]) begin
				sh_s2 = 3'(j - COMP_LIMIT_LOG + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				c_s2[k] <= CMP_W'(32'(q_s1[k]) >>> sh_s2);
			end
			deg_s2 <= (m_s1 == '0);
		end
	end

	// Stage 3: squares and cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s3[P_XX] <= c_s2[0] * c_s2[0];
			p_s3[P_YY] <= c_s2[1] * c_s2[1];
			p_s3[P_ZZ] <= c_s2[2] * c_s2[2];
			p_s3[P_WW] <= c_s2[3] * c_s2[3];
			p_s3[P_XY] <= c_s2[0] * c_s2[1];
			p_s3[P_ZW] <= c_s2[2] * c_s2[3];
			p_s3[P_XZ] <= c_s2[0] * c_s2[2];
			p_s3[P_YW] <= c_s2[1] * c_s2[3];
			p_s3[P_YZ] <= c_s2[1] * c_s2[2];
			p_s3[P_XW] <= c_s2[0] * c_s2[3];
			deg_s3     <= deg_s2;
		end
	end

	// Stage 4: squared length and matrix numerators.
	always_comb begin
		t_nxt[T_L]  = SUM_W'(p_s3[P_WW]) + SUM_W'(p_s3[P_XX])
			+ SUM_W'(p_s3[P_YY]) + SUM_W'(p_s3[P_ZZ]);
		t_nxt[T_00] = SUM_W'(p_s3[P_WW]) + SUM_W'(p_s3[P_XX])
			- SUM_W'(p_s3[P_YY]) - SUM_W'(p_s3[P_ZZ]);
		t_nxt[T_11] = SUM_W'(p_s3[P_WW]) - SUM_W'(p_s3[P_XX])
			+ SUM_W'(p_s3[P_YY]) - SUM_W'(p_s3[P_ZZ]);
		t_nxt[T_22] = SUM_W'(p_s3[P_WW]) - SUM_W'(p_s3[P_XX])
			- SUM_W'(p_s3[P_YY]) + SUM_W'(p_s3[P_ZZ]);
		t_nxt[T_01] = (SUM_W'(p_s3[P_XY]) + SUM_W'(p_s3[P_ZW])) <<< 1;
		t_nxt[T_10] = (SUM_W'(p_s3[P_XY]) - SUM_W'(p_s3[P_ZW])) <<< 1;
		t_nxt[T_02] = (SUM_W'(p_s3[P_XZ]) - SUM_W'(p_s3[P_YW])) <<< 1;
		t_nxt[T_12] = (SUM_W'(p_s3[P_YZ]) + SUM_W'(p_s3[P_XW])) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4   <= t_nxt;
			deg_s4 <= deg_s3;
		end
	end

	// Stage 5: position of the top set bit of the squared length.
	always_comb begin
		top_bit = '0;
		for (int j = 0; j < SUM_W; j++) begin
			if (t_s4[T_L][j]) begin
				top_bit = 6'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s5   <= t_s4;
			p_s5   <= top_bit;
			deg_s5 <= deg_s4;
		end
	end

	// Stage 6: common power-of-two scaling that puts the length's top bit at NORM_TOP.
	assign sh_r = p_s5 - 6'(NORM_TOP);
	assign sh_l = 6'(NORM_TOP) - p_s5;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			if (p_s5 > 6'(NORM_TOP)) begin
				t_nrm[k] = t_s5[k] >>> sh_r;
			end else begin
				t_nrm[k] = t_s5[k] <<< sh_l;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			terms_s6.deg <= deg_s5;
			terms_s6.len <= LEN_W'(t_nrm[T_L]);
			terms_s6.n00 <= CORDIC_W'(t_nrm[T_00]);
			terms_s6.n01 <= CORDIC_W'(t_nrm[T_01]);
			terms_s6.n02 <= CORDIC_W'(t_nrm[T_02]);
			terms_s6.n10 <= CORDIC_W'(t_nrm[T_10]);
			terms_s6.n11 <= CORDIC_W'(t_nrm[T_11]);
			terms_s6.n12 <= CORDIC_W'(t_nrm[T_12]);
			terms_s6.n22 <= CORDIC_W'(t_nrm[T_22]);
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign out_valid = vld_s6;
	assign terms     = terms_s6;

endmodule

@@ hw/rtl/qte_cordic.sv @@
// Pipelined CORDIC in vectoring mode: one pre-rotation stage, then one stage per iteration.
module qte_cordic #(
	parameter int W      = qte_pkg::CORDIC_W,
	parameter int ZW     = qte_pkg::ANG_Z_W,
	parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF,
	parameter int TW     = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [W-1:0]  x_in,
	input  logic signed [W-1:0]  y_in,
	input  logic [TW-1:0]        tag_in,
	output logic                 out_valid,
	output logic signed [W-1:0]  x_out,
	output logic signed [ZW-1:0] z_out,
	output logic [TW-1:0]        tag_out
);
	import qte_pkg::*;

	localparam logic signed [ZW-1:0] HALF_PI = ZW'(HALF_PI_UNITS);

	logic signed [W-1:0]  x_s   [0:STAGES];
	logic signed [W-1:0]  y_s   [0:STAGES];
	logic signed [ZW-1:0] z_s   [0:STAGES];
	logic                 zero_s[0:STAGES];
	logic                 vld_s [0:STAGES];
	logic [TW-1:0]        tag_s [0:STAGES];
	logic signed [W-1:0]  x_pre, y_pre;
	logic signed [ZW-1:0] z_pre;

	// Vectors in the left half-plane are first turned by a quarter turn.
	always_comb begin
		x_pre = x_in;
		y_pre = y_in;
		z_pre = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x_pre = y_in;
				y_pre = -x_in;
				z_pre = HALF_PI;
			end else begin
				x_pre = -y_in;
				y_pre = x_in;
				z_pre = -HALF_PI;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x_pre;
			y_s[0]    <= y_pre;
			z_s[0]    <= z_pre;
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			tag_s[0]  <= tag_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// One micro-rotation per stage, driving y toward zero.
	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_TAB[i]);
		logic signed [W-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN_I;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN_I;
				end
				zero_s[i+1] <= zero_s[i];
				tag_s[i+1]  <= tag_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	// A zero vector reports angle zero.
	assign out_valid = vld_s[STAGES];
	assign x_out     = x_s[STAGES];
	assign z_out     = zero_s[STAGES] ? '0 : z_s[STAGES];
	assign tag_out   = tag_s[STAGES];

endmodule

@@ hw/rtl/quaternion_to_euler_angles.sv @@
// Top level of the quaternion to Z*Y*X Euler angle converter.
// Path: front end, the two CORDIC banks in series, then the gain and gimbal lock stages.
// Throughput is one quaternion per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits and sets the gimbal lock threshold to 1.
module quaternion_to_euler_angles #(
	parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF,
	parameter int ANGLE_BITS     = qte_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES  = qte_pkg::CORDIC_STAGES_DEF,
	localparam int IN_W  = ((4 * COMPONENT_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * ANGLE_BITS + 2 + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// quat_x, quat_y, quat_z, quat_w from the lowest bit up
	input  logic [IN_W-1:0]               s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// roll_angle, pitch_angle, yaw_angle, gimbal_lock, degenerate from the lowest bit up
	output logic [OUT_W-1:0]              m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qte_pkg::THR_BITS-1:0]  cfg_data
);
	import qte_pkg::*;

	localparam int CB    = COMPONENT_BITS;
	localparam int AB    = ANGLE_BITS;
	localparam int SH    = 32 - AB;
	localparam int TA_W  = CORDIC_W + LEN_W + 1;
	localparam int TP_W  = 2 * ANG_Z_W + 2;
	localparam int PRD_W = CORDIC_W + GAIN_SHIFT;
	localparam int TL_W  = THR_BITS + LEN_W;
	localparam logic signed [ANG_Z_W-1:0] ANG_HI = ANG_Z_W'((64'sd1 <<< (AB - 1)) - 64'sd1);
	localparam logic signed [ANG_Z_W-1:0] ANG_LO = -ANG_HI - ANG_Z_W'(1);

	// Round to the output angle width and saturate.
	function automatic logic [AB-1:0] to_angle(input logic signed [ANG_Z_W-1:0] z);
		logic signed [ANG_Z_W-1:0] r;
		r = (z + ((ANG_Z_W'(1) <<< SH) >>> 1)) >>> SH;
		if (r > ANG_HI) begin
			r = ANG_HI;
		end else if (r < ANG_LO) begin
			r = ANG_LO;
		end
		return AB'(r);
	endfunction

	logic                        en;
	logic [THR_BITS-1:0]         thr_q;
	logic                        front_vld;
	qte_terms_t                  terms;
	logic                        a_vld;
	logic signed [CORDIC_W-1:0]  hyp_x;
	logic signed [ANG_Z_W-1:0]   yawn_z, roll_z, yawl_z;
	logic [TA_W-1:0]             a_tag;
	logic signed [CORDIC_W-1:0]  n12_neg, n10_neg;
	logic [PRD_W-1:0]            prod_s1;
	logic [TL_W-1:0]             tl_s1;
	logic signed [CORDIC_W-1:0]  n02_s1;
	logic signed [ANG_Z_W-1:0]   roll_s1, yawn_s1, yawl_s1;
	logic                        deg_s1, vld_s1;
	logic [CORDIC_W-1:0]         h_nxt;
	logic signed [CORDIC_W-1:0]  h_s2, n02_s2;
	logic signed [ANG_Z_W-1:0]   roll_s2, yaw_s2;
	logic                        lock_s2, deg_s2, vld_s2;
	logic                        p_vld;
	logic signed [ANG_Z_W-1:0]   pitch_z;
	logic [TP_W-1:0]             p_tag;
	logic signed [ANG_Z_W-1:0]   p_yaw, p_roll;
	logic                        p_lock, p_deg;
	logic [AB-1:0]               roll_s3, pitch_s3, yaw_s3;
	logic                        lock_s3, deg_s3, vld_s3;

	// The pipeline advances whenever the output register is free or being drained.
	assign en        = !vld_s3 || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// Gimbal lock threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_BITS'(1);
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	qte_front #(
		.COMPONENT_BITS(CB)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.quat_x   (s_tdata[CB-1:0]),
		.quat_y   (s_tdata[2*CB-1:CB]),
		.quat_z   (s_tdata[3*CB-1:2*CB]),
		.quat_w   (s_tdata[4*CB-1:3*CB]),
		.out_valid(front_vld),
		.terms    (terms)
	);

	// First bank: hypot of (r00, r01) with yaw, roll, and yaw under gimbal lock.
	assign n12_neg = -terms.n12;
	assign n10_neg = -terms.n10;

	qte_cordic #(
		.W(CORDIC_W), .ZW(ANG_Z_W), .STAGES(CORDIC_STAGES), .TW(TA_W)
	) u_cordic_hyp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (front_vld),
		.x_in     (terms.n00),
		.y_in     (terms.n01),
		.tag_in   ({terms.n02, terms.len, terms.deg}),
		.out_valid(a_vld),
		.x_out    (hyp_x),
		.z_out    (yawn_z),
		.tag_out  (a_tag)
	);

	qte_cordic #(
		.W(CORDIC_W), .ZW(ANG_Z_W), .STAGES(CORDIC_STAGES), .TW(1)
	) u_cordic_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (front_vld),
		.x_in     (terms.n22),
		.y_in     (n12_neg),
		.tag_in   (1'b0),
		.out_valid(),
		.x_out    (),
		.z_out    (roll_z),
		.tag_out  ()
	);

	qte_cordic #(
		.W(CORDIC_W), .ZW(ANG_Z_W), .STAGES(CORDIC_STAGES), .TW(1)
	) u_cordic_yawl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (front_vld),
		.x_in     (terms.n11),
		.y_in     (n10_neg),
		.tag_in   (1'b0),
		.out_valid(),
		.x_out    (),
		.z_out    (yawl_z),
		.tag_out  ()
	);

	// Stage 1: gain compensation product and threshold times length.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PRD_W'($unsigned(hyp_x)) * PRD_W'(INV_GAIN_Q20);
			tl_s1   <= TL_W'(thr_q) * TL_W'(a_tag[LEN_W:1]);
			n02_s1  <= a_tag[TA_W-1:LEN_W+1];
			deg_s1  <= a_tag[0];
			roll_s1 <= roll_z;
			yawn_s1 <= yawn_z;
			yawl_s1 <= yawl_z;
		end
	end

	// Stage 2: hypot, gimbal lock decision and yaw selection.
	assign h_nxt = CORDIC_W'(prod_s1 >> GAIN_SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			h_s2    <= $signed(h_nxt);
			n02_s2  <= n02_s1;
			lock_s2 <= (64'(h_nxt) << THR_BITS) <= 64'(tl_s1);
			roll_s2 <= roll_s1;
			yaw_s2  <= ((64'(h_nxt) << THR_BITS) <= 64'(tl_s1)) ? yawl_s1 : yawn_s1;
			deg_s2  <= deg_s1;
		end
	end

	// Second bank: pitch from r02 against the hypot.
	qte_cordic #(
		.W(CORDIC_W), .ZW(ANG_Z_W), .STAGES(CORDIC_STAGES), .TW(TP_W)
	) u_cordic_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.x_in     (h_s2),
		.y_in     (n02_s2),
		.tag_in   ({yaw_s2, roll_s2, lock_s2, deg_s2}),
		.out_valid(p_vld),
		.x_out    (),
		.z_out    (pitch_z),
		.tag_out  (p_tag)
	);

	assign p_yaw  = p_tag[TP_W-1:ANG_Z_W+2];
	assign p_roll = p_tag[ANG_Z_W+1:2];
	assign p_lock = p_tag[1];
	assign p_deg  = p_tag[0];

	// Stage 3: rounded output register; a zero quaternion gives zero angles and no lock.
	always_ff @(posedge clk) begin
		if (en) begin
			roll_s3  <= (p_lock || p_deg) ? '0 : to_angle(p_roll);
			pitch_s3 <= p_deg ? '0 : to_angle(pitch_z);
			yaw_s3   <= p_deg ? '0 : to_angle(p_yaw);
			lock_s3  <= p_lock && !p_deg;
			deg_s3   <= p_deg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= a_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= p_vld;
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = OUT_W'({deg_s3, lock_s3, yaw_s3, pitch_s3, roll_s3});

endmodule
